/* design/ertm_pkg.sv */
// ----------------------------------------------------------------------------
// ertm_pkg
// Shared constants for the Euler-angle to rotation-matrix pipeline.
// ----------------------------------------------------------------------------
package ertm_pkg;

    localparam int CORDIC_W     = 34;
    localparam int INT_FRAC     = 30;
    localparam int CORDIC_EXTRA = 2;   // reduce stage + narrow stage
    localparam int MATRIX_DEPTH = 4;
    localparam logic signed [CORDIC_W-1:0] CORDIC_START = 34'sd652032874;

    localparam logic [31:0] ATAN_TABLE [0:31] = '{
        32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
        32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
    };

endpackage

/* design/ertm_cordic.sv */
// ----------------------------------------------------------------------------
// ertm_cordic
// Pipelined sine/cosine: quadrant fold, one CORDIC rotation per stage, and a
// final round and saturate to the entry format.
// ----------------------------------------------------------------------------
module ertm_cordic #(
    parameter int ANGLE_BITS    = 16,
    parameter int FRACTION_BITS = 14,
    parameter int CORDIC_STAGES = 16
) (
    input  logic                            i_clk,
    input  logic                            i_en,
    input  logic signed [ANGLE_BITS-1:0]    i_angle,
    output logic signed [FRACTION_BITS+1:0] o_sin,
    output logic signed [FRACTION_BITS+1:0] o_cos
);
    localparam int W  = ertm_pkg::CORDIC_W;
    localparam int S  = CORDIC_STAGES;
    localparam int SH = ertm_pkg::INT_FRAC - FRACTION_BITS;
    localparam logic signed [W-1:0] QUARTER = W'(64'sd1 <<< 30);
    localparam logic signed [W-1:0] HALF    = W'(64'sd1 <<< 31);
    localparam logic signed [W-1:0] ONE     = W'(64'sd1 <<< FRACTION_BITS);
    localparam logic signed [W-1:0] RND     = (SH > 0) ? W'(64'sd1 <<< (SH - 1)) : '0;

    logic signed [W-1:0] r_x [0:S];
    logic signed [W-1:0] r_y [0:S];
    logic signed [W-1:0] r_z [0:S];
    logic                r_neg [0:S];

    logic signed [W-1:0] n_z0;
    logic                n_neg0;

    always_comb begin
        n_z0   = $signed({{(W-ANGLE_BITS){i_angle[ANGLE_BITS-1]}}, i_angle}) <<< (32 - ANGLE_BITS);
        n_neg0 = 1'b0;
        if (n_z0 > QUARTER) begin
            n_z0   = n_z0 - HALF;
            n_neg0 = 1'b1;
        end else if (n_z0 < -QUARTER) begin
            n_z0   = n_z0 + HALF;
            n_neg0 = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0]   <= ertm_pkg::CORDIC_START;
            r_y[0]   <= '0;
            r_z[0]   <= n_z0;
            r_neg[0] <= n_neg0;
        end
    end

    for (genvar i = 0; i < S; i++) begin : g_stage
        localparam logic signed [W-1:0] ATAN = $signed({2'b00, ertm_pkg::ATAN_TABLE[i % 32]});
        logic signed [W-1:0] dx;
        logic signed [W-1:0] dy;
        assign dx = r_y[i] >>> i;
        assign dy = r_x[i] >>> i;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (!r_z[i][W-1]) begin
                    r_x[i+1] <= r_x[i] - dx;
                    r_y[i+1] <= r_y[i] + dy;
                    r_z[i+1] <= r_z[i] - ATAN;
                end else begin
                    r_x[i+1] <= r_x[i] + dx;
                    r_y[i+1] <= r_y[i] - dy;
                    r_z[i+1] <= r_z[i] + ATAN;
                end
                r_neg[i+1] <= r_neg[i];
            end
        end
    end

    logic signed [W-1:0] w_c;
    logic signed [W-1:0] w_s;
    logic signed [W-1:0] n_c;
    logic signed [W-1:0] n_s;

    always_comb begin
        w_c = r_neg[S] ? -r_x[S] : r_x[S];
        w_s = r_neg[S] ? -r_y[S] : r_y[S];
        n_c = (w_c + RND) >>> SH;
        n_s = (w_s + RND) >>> SH;
        if (n_c > ONE)  n_c = ONE;
        if (n_c < -ONE) n_c = -ONE;
        if (n_s > ONE)  n_s = ONE;
        if (n_s < -ONE) n_s = -ONE;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_cos <= n_c[FRACTION_BITS+1:0];
            o_sin <= n_s[FRACTION_BITS+1:0];
        end
    end

endmodule

/* design/ertm_matrix.sv */
// ----------------------------------------------------------------------------
// ertm_matrix
// Four-stage product pipeline: pair products, rounding, triple products,
// then rounding, sums and saturation of the nine entries.
// ----------------------------------------------------------------------------
module ertm_matrix #(
    parameter int FRACTION_BITS = 14
) (
    input  logic                            i_clk,
    input  logic                            i_en,
    input  logic signed [FRACTION_BITS+1:0] i_sx,
    input  logic signed [FRACTION_BITS+1:0] i_cx,
    input  logic signed [FRACTION_BITS+1:0] i_sy,
    input  logic signed [FRACTION_BITS+1:0] i_cy,
    input  logic signed [FRACTION_BITS+1:0] i_sz,
    input  logic signed [FRACTION_BITS+1:0] i_cz,
    output logic signed [FRACTION_BITS+1:0] o_e [0:8]
);
    localparam int F  = FRACTION_BITS;
    localparam int E  = F + 2;
    localparam int PW = 2 * E;
    localparam int SW = F + 4;
    localparam logic signed [PW-1:0] HALF = PW'(64'sd1 <<< (F - 1));
    localparam logic signed [SW-1:0] ONE  = SW'(64'sd1 <<< F);

    function automatic logic signed [E-1:0] rnd(input logic signed [PW-1:0] p);
        logic signed [PW-1:0] t;
        t = (p + HALF) >>> F;
        return t[E-1:0];
    endfunction

    function automatic logic signed [SW-1:0] ext(input logic signed [E-1:0] v);
        return {{(SW-E){v[E-1]}}, v};
    endfunction

    function automatic logic signed [E-1:0] sat(input logic signed [SW-1:0] v);
        logic signed [SW-1:0] t;
        t = v;
        if (t > ONE)  t = ONE;
        if (t < -ONE) t = -ONE;
        return t[E-1:0];
    endfunction

    // pair order: cycz sycz cysz sysz czcx czsx sysx cysx sycx cycx
    logic signed [PW-1:0] r_p [0:9];
    logic signed [E-1:0]  r_q [0:9];
    logic signed [E-1:0]  r_sx1, r_cx1, r_sz1, r_sx2, r_cx2, r_sz2, r_sz3;
    logic signed [E-1:0]  r_q3 [0:9];
    logic signed [PW-1:0] r_t [0:3];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p[0] <= i_cy * i_cz;
            r_p[1] <= i_sy * i_cz;
            r_p[2] <= i_cy * i_sz;
            r_p[3] <= i_sy * i_sz;
            r_p[4] <= i_cz * i_cx;
            r_p[5] <= i_cz * i_sx;
            r_p[6] <= i_sy * i_sx;
            r_p[7] <= i_cy * i_sx;
            r_p[8] <= i_sy * i_cx;
            r_p[9] <= i_cy * i_cx;
            r_sx1  <= i_sx;
            r_cx1  <= i_cx;
            r_sz1  <= i_sz;

            for (int k = 0; k < 10; k++) r_q[k] <= rnd(r_p[k]);
            r_sx2 <= r_sx1;
            r_cx2 <= r_cx1;
            r_sz2 <= r_sz1;

            r_t[0] <= r_q[2] * r_cx2;
            r_t[1] <= r_q[3] * r_cx2;
            r_t[2] <= r_q[2] * r_sx2;
            r_t[3] <= r_q[3] * r_sx2;
            for (int k = 0; k < 10; k++) r_q3[k] <= r_q[k];
            r_sz3 <= r_sz2;

            o_e[0] <= sat(ext(r_q3[0]));
            o_e[1] <= sat(ext(r_sz3));
            o_e[2] <= sat(-ext(r_q3[1]));
            o_e[3] <= sat(ext(r_q3[6]) - ext(rnd(r_t[0])));
            o_e[4] <= sat(ext(r_q3[4]));
            o_e[5] <= sat(ext(rnd(r_t[1])) + ext(r_q3[7]));
            o_e[6] <= sat(ext(rnd(r_t[2])) + ext(r_q3[8]));
            o_e[7] <= sat(-ext(r_q3[5]));
            o_e[8] <= sat(ext(r_q3[9]) - ext(rnd(r_t[3])));
        end
    end

endmodule

/* design/euler_to_rotation_matrix_core.sv */
// ----------------------------------------------------------------------------
// euler_to_rotation_matrix_core
// Euler angles and translation to a 3x3 rotation matrix plus translation.
// ----------------------------------------------------------------------------
// One item is accepted per cycle while o_stall is low; each result passes
// through one fold stage, one register per CORDIC rotation, one narrowing
// stage, then four stages of the product pipeline.
// A stall at the output while a result is held freezes the whole pipeline,
// and the input stall (o_stall) follows it.
module euler_to_rotation_matrix_core #(
    parameter int ANGLE_BITS    = 16,
    parameter int FRACTION_BITS = 14,
    parameter int CORDIC_STAGES = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic signed [ANGLE_BITS-1:0]    i_angle_x,
    input  logic signed [ANGLE_BITS-1:0]    i_angle_y,
    input  logic signed [ANGLE_BITS-1:0]    i_angle_z,
    input  logic signed [31:0]              i_pos_x_in,
    input  logic signed [31:0]              i_pos_y_in,
    input  logic signed [31:0]              i_pos_z_in,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic signed [FRACTION_BITS+1:0] o_c0_r0,
    output logic signed [FRACTION_BITS+1:0] o_c0_r1,
    output logic signed [FRACTION_BITS+1:0] o_c0_r2,
    output logic signed [FRACTION_BITS+1:0] o_c1_r0,
    output logic signed [FRACTION_BITS+1:0] o_c1_r1,
    output logic signed [FRACTION_BITS+1:0] o_c1_r2,
    output logic signed [FRACTION_BITS+1:0] o_c2_r0,
    output logic signed [FRACTION_BITS+1:0] o_c2_r1,
    output logic signed [FRACTION_BITS+1:0] o_c2_r2,
    output logic signed [31:0]              o_pos_x_out,
    output logic signed [31:0]              o_pos_y_out,
    output logic signed [31:0]              o_pos_z_out
);
    localparam int N = CORDIC_STAGES + ertm_pkg::CORDIC_EXTRA + ertm_pkg::MATRIX_DEPTH;
    localparam int E = FRACTION_BITS + 2;

    logic                w_en;
    logic [N-1:0]        r_vld;
    logic signed [31:0]  r_px [0:N-1];
    logic signed [31:0]  r_py [0:N-1];
    logic signed [31:0]  r_pz [0:N-1];
    logic signed [E-1:0] w_sx, w_cx, w_sy, w_cy, w_sz, w_cz;
    logic signed [E-1:0] w_e [0:8];

    assign w_en    = !(r_vld[N-1] && i_stall);
    assign o_stall = !w_en;
    assign o_valid = r_vld[N-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[N-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_px[0] <= i_pos_x_in;
            r_py[0] <= i_pos_y_in;
            r_pz[0] <= i_pos_z_in;
            for (int k = 1; k < N; k++) begin
                r_px[k] <= r_px[k-1];
                r_py[k] <= r_py[k-1];
                r_pz[k] <= r_pz[k-1];
            end
        end
    end

    ertm_cordic #(.ANGLE_BITS(ANGLE_BITS), .FRACTION_BITS(FRACTION_BITS),
                  .CORDIC_STAGES(CORDIC_STAGES)) u_cordic_x (
        .i_clk(i_clk), .i_en(w_en), .i_angle(i_angle_x), .o_sin(w_sx), .o_cos(w_cx));
    ertm_cordic #(.ANGLE_BITS(ANGLE_BITS), .FRACTION_BITS(FRACTION_BITS),
                  .CORDIC_STAGES(CORDIC_STAGES)) u_cordic_y (
        .i_clk(i_clk), .i_en(w_en), .i_angle(i_angle_y), .o_sin(w_sy), .o_cos(w_cy));
    ertm_cordic #(.ANGLE_BITS(ANGLE_BITS), .FRACTION_BITS(FRACTION_BITS),
                  .CORDIC_STAGES(CORDIC_STAGES)) u_cordic_z (
        .i_clk(i_clk), .i_en(w_en), .i_angle(i_angle_z), .o_sin(w_sz), .o_cos(w_cz));

    ertm_matrix #(.FRACTION_BITS(FRACTION_BITS)) u_matrix (
        .i_clk(i_clk), .i_en(w_en),
        .i_sx(w_sx), .i_cx(w_cx), .i_sy(w_sy), .i_cy(w_cy), .i_sz(w_sz), .i_cz(w_cz),
        .o_e(w_e));

    assign o_c0_r0 = w_e[0];
    assign o_c0_r1 = w_e[1];
    assign o_c0_r2 = w_e[2];
    assign o_c1_r0 = w_e[3];
    assign o_c1_r1 = w_e[4];
    assign o_c1_r2 = w_e[5];
    assign o_c2_r0 = w_e[6];
    assign o_c2_r1 = w_e[7];
    assign o_c2_r2 = w_e[8];
    assign o_pos_x_out = r_px[N-1];
    assign o_pos_y_out = r_py[N-1];
    assign o_pos_z_out = r_pz[N-1];

endmodule

/* design/ertm_checker.sv */
// ----------------------------------------------------------------------------
// ertm_checker
// Port-level checks for the rotation-matrix core, bound to the top level.
// ----------------------------------------------------------------------------
module ertm_checker #(
    parameter int FRACTION_BITS = 14
) (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            o_stall,
    input logic                            o_valid,
    input logic                            i_stall,
    input logic signed [FRACTION_BITS+1:0] o_c0_r0,
    input logic signed [FRACTION_BITS+1:0] o_c0_r1,
    input logic signed [FRACTION_BITS+1:0] o_c1_r1,
    input logic signed [31:0]              o_pos_x_out
);
    localparam logic signed [FRACTION_BITS+1:0] ONE = (FRACTION_BITS+2)'(1 << FRACTION_BITS);

    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("item valid right after reset");

    a_stall_only_when_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled with no held item");

    a_held_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_pos_x_out) && $stable(o_c0_r0)))
        else $error("held item changed");

    a_entry_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_c0_r0 <= ONE && o_c0_r0 >= -ONE && o_c0_r1 <= ONE
                     && o_c0_r1 >= -ONE && o_c1_r1 <= ONE && o_c1_r1 >= -ONE))
        else $error("entry beyond unit range");

endmodule

bind euler_to_rotation_matrix_core ertm_checker #(
    .FRACTION_BITS(FRACTION_BITS)
) u_ertm_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_stall(o_stall),
    .o_valid(o_valid), .i_stall(i_stall),
    .o_c0_r0(o_c0_r0), .o_c0_r1(o_c0_r1), .o_c1_r1(o_c1_r1),
    .o_pos_x_out(o_pos_x_out)
);
